@@ hw/rtl/linear_array_deque_assert.svh @@
// Assertion macros shared by the deque RTL.
// Expects signals named clock and reset in the scope of use.
`ifndef LINEAR_ARRAY_DEQUE_ASSERT_SVH
`define LINEAR_ARRAY_DEQUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define LAD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define LAD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/lad_pkg.sv @@
// Shared types and constants for the linear array deque.
// No dependencies; used by lad_ctrl, lad_dpath and linear_array_deque.
package lad_pkg;

   localparam int OP_W        = 2;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int CFG_W       = 7;
   localparam logic [CFG_W-1:0] CFG_DEPTH_RESET = 7'd64;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 2'd0,
      OP_INS_REAR  = 2'd1,
      OP_DEL_FRONT = 2'd2,
      OP_DEL_REAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_EMPTY   = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request transaction
      logic exec;     // apply the operation to indices and store
      logic capture;  // latch read data into the response
      logic cfg_we;   // write the capacity register
   } lad_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_read;  // operation is a delete on a non-empty deque
   } lad_sts_type;

endpackage

@@ hw/rtl/lad_ctrl.sv @@
// Sequencer for the linear array deque: handshakes and datapath commands.
// Depends on lad_pkg.
module lad_ctrl import lad_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        csr_valid,
   output logic        csr_ready,
   output lad_cmd_type cmd,
   input  lad_sts_type sts
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      idle_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept    = (state_ff == S_IDLE) && idle_ff && req_valid;
   assign req_stall = ~idle_ff;
   assign csr_ready = idle_ff;
   assign rsp_valid = rsp_valid_ff;

   // commands to the datapath
   always_comb begin
      cmd.load    = accept;
      cmd.exec    = (state_ff == S_EXEC);
      cmd.capture = (state_ff == S_READ);
      cmd.cfg_we  = csr_valid && idle_ff;
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idle_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_EXEC;
                  idle_ff  <= 1'b0;
               end else begin
                  idle_ff  <= 1'b1;
               end
            end
            S_EXEC: begin
               if (sts.needs_read) begin
                  state_ff <= S_READ;
               end else begin
                  state_ff     <= S_RESP;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_READ: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
                  idle_ff      <= 1'b1;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
               idle_ff      <= 1'b0;
            end
         endcase
      end
   end

endmodule

@@ hw/rtl/lad_dpath.sv @@
// Datapath of the linear array deque: slot memory, indices, capacity
// register and response registers. Depends on lad_pkg.
module lad_dpath import lad_pkg::*; #(
   parameter int DEPTH     = 64,
   parameter int DATA_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lad_cmd_type               cmd,
   output lad_sts_type               sts,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [VALUE_W-1:0] req_item_value,
   input  logic [CFG_W-1:0]          csr_used_depth,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_removed_value,
   output logic                      rsp_now_empty
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;
   localparam logic [CMP_W-1:0] DEPTH_C   = CMP_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

   // control state
   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] rear_ff, rear_in;
   logic             empty_ff, empty_in;
   logic [CFG_W-1:0] used_depth_ff;

   // request and response payload
   op_type              op_ff;
   logic [VALUE_W-1:0]  value_ff;
   status_type          status_ff, status_in;
   logic [VALUE_W-1:0]  removed_ff;
   logic                now_empty_ff;

   // slot store
   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;
   logic [DATA_BITS-1:0] wr_data;

   logic [CMP_W-1:0] depth_w;
   logic [IDX_W-1:0] last_slot;
   logic             needs_read;

   assign wr_data = DATA_BITS'(value_ff);

   // last usable slot, with capacity clamped to 1..DEPTH
   assign depth_w = CMP_W'(used_depth_ff);
   always_comb begin
      if (depth_w == '0) begin
         last_slot = '0;
      end else if (depth_w > DEPTH_C) begin
         last_slot = LAST_SLOT;
      end else begin
         last_slot = IDX_W'(depth_w - 1'b1);
      end
   end

   // operation decode: next indices, store access, status
   always_comb begin
      front_in   = front_ff;
      rear_in    = rear_ff;
      empty_in   = empty_ff;
      status_in  = ST_DONE;
      wr_en      = 1'b0;
      wr_addr    = front_ff;
      rd_addr    = front_ff;
      needs_read = 1'b0;
      case (op_ff)
         OP_INS_FRONT, OP_INS_REAR: begin
            if (empty_ff) begin
               // first value always lands in slot 0
               front_in = '0;
               rear_in  = '0;
               empty_in = 1'b0;
               wr_en    = cmd.exec;
               wr_addr  = '0;
            end else if (op_ff == OP_INS_FRONT) begin
               if (front_ff == '0) begin
                  status_in = ST_NO_ROOM;
               end else begin
                  front_in = front_ff - 1'b1;
                  wr_en    = cmd.exec;
                  wr_addr  = front_in;
               end
            end else begin
               // at or past the last slot also covers a shrunk capacity
               if (rear_ff >= last_slot) begin
                  status_in = ST_NO_ROOM;
               end else begin
                  rear_in = rear_ff + 1'b1;
                  wr_en   = cmd.exec;
                  wr_addr = rear_in;
               end
            end
         end
         OP_DEL_FRONT, OP_DEL_REAR: begin
            if (empty_ff) begin
               status_in = ST_EMPTY;
            end else begin
               needs_read = 1'b1;
               rd_addr    = (op_ff == OP_DEL_FRONT) ? front_ff : rear_ff;
               if (front_ff == rear_ff) begin
                  front_in = '0;
                  rear_in  = '0;
                  empty_in = 1'b1;
               end else if (op_ff == OP_DEL_FRONT) begin
                  front_in = front_ff + 1'b1;
               end else begin
                  rear_in = rear_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign sts.needs_read = needs_read;

   // indices, empty flag and capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         rear_ff       <= '0;
         empty_ff      <= 1'b1;
         used_depth_ff <= CFG_DEPTH_RESET;
      end else begin
         if (cmd.cfg_we) begin
            used_depth_ff <= csr_used_depth;
         end
         if (cmd.exec) begin
            front_ff <= front_in;
            rear_ff  <= rear_in;
            empty_ff <= empty_in;
         end
      end
   end

   // request and response payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         value_ff <= $unsigned(req_item_value);
      end
      if (cmd.exec) begin
         status_ff    <= status_in;
         now_empty_ff <= empty_in;
         removed_ff   <= '0;
      end
      if (cmd.capture) begin
         removed_ff <= VALUE_W'(rd_data_ff);
      end
   end

   // slot store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_status        = status_ff;
   assign rsp_removed_value = $signed(removed_ff);
   assign rsp_now_empty     = now_empty_ff;

endmodule

@@ hw/rtl/linear_array_deque.sv @@
// Linear (non-circular) array deque with a programmable capacity. Each request
// transaction inserts at the front or rear, or deletes from the front or rear,
// and gives exactly one response transaction: a status (done, no room at that
// end, or empty), the removed value for a successful delete (zero otherwise),
// and whether the deque is empty afterwards. Indices never wrap: the front end
// is full at slot 0 and the rear end at the last slot of the capacity set via
// the csr channel (0 acts as 1, values above DEPTH act as DEPTH). One request
// is handled at a time: an insert or a failed request shows its response after
// the execute state, a successful delete after the execute and read states, the
// read state covering the slot memory's registered read port. The next request
// is accepted in the cycle after the response is taken. The capacity
// register should be written only while no request is outstanding;
// csr_ready is high then.
// Depends on lad_pkg, lad_ctrl, lad_dpath and linear_array_deque_assert.svh.
`include "linear_array_deque_assert.svh"

module linear_array_deque import lad_pkg::*; #(
   parameter int DEPTH     = 64,
   parameter int DATA_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [VALUE_W-1:0] req_item_value,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_removed_value,
   output logic                      rsp_now_empty,
   // capacity register write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CFG_W-1:0]          csr_used_depth
);

   lad_cmd_type cmd;
   lad_sts_type sts;

   // sequencer
   lad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // storage and indices
   lad_dpath #(
      .DEPTH     (DEPTH),
      .DATA_BITS (DATA_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_op            (req_op),
      .req_item_value    (req_item_value),
      .csr_used_depth    (csr_used_depth),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_now_empty     (rsp_now_empty)
   );

   // only one transaction in flight: no new request while a response waits
   `LAD_ASSERT_NOW(a_single_item, rsp_valid, req_stall, "request accepted while response pending")
   // an empty-deque delete reports empty and removes nothing
   `LAD_ASSERT_NOW(a_empty_resp, rsp_valid && (rsp_status == ST_EMPTY), rsp_now_empty && (rsp_removed_value == '0), "bad empty response")
   // no room is only possible while holding values
   `LAD_ASSERT_NOW(a_no_room_resp, rsp_valid && (rsp_status == ST_NO_ROOM), !rsp_now_empty && (rsp_removed_value == '0), "bad no-room response")
   // a request never yields its response in the following cycle
   `LAD_ASSERT_NEXT(a_min_latency, req_valid && !req_stall, !rsp_valid, "response too early")

endmodule
